// ----- hw/rtl/fcbv_pkg.sv -----
// fcbv_pkg: widths, codes and shared types of the frustum culling block
// used by fcbv_plane_regs, fcbv_plane_lane and frustum_cull_bound_volume
package fcbv_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int COEF_WIDTH      = 16;
    localparam int COEF_FRAC_BITS  = 14;
    localparam int EXT_WIDTH       = 15;
    localparam int PLANE_COUNT     = 6;
    localparam int PLANE_FRONT     = 5;
    localparam int AXIS_COUNT      = 3;
    localparam int PROD_WIDTH      = COEF_WIDTH + COORD_WIDTH;
    localparam int EPROD_WIDTH     = COEF_WIDTH + EXT_WIDTH + 1;
    // plane value plus extent terms stays below 2^33 in magnitude
    localparam int SUM_WIDTH       = 36;
    localparam int NEAR_WIDTH      = 38;
    localparam int VIS_WIDTH       = 2;
    localparam int KIND_WIDTH      = 2;
    localparam int CFG_IDX_WIDTH   = 3;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int S_DATA_WIDTH    = 96;
    localparam int M_DATA_WIDTH    = 40;

    localparam logic [KIND_WIDTH-1:0] KIND_SPHERE = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_CUBE   = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_BOX    = 2'd2;

    localparam logic [VIS_WIDTH-1:0] VIS_NONE  = 2'd0;
    localparam logic [VIS_WIDTH-1:0] VIS_PART  = 2'd1;
    localparam logic [VIS_WIDTH-1:0] VIS_WHOLE = 2'd2;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] off;
        logic signed [COEF_WIDTH-1:0] nz;
        logic signed [COEF_WIDTH-1:0] ny;
        logic signed [COEF_WIDTH-1:0] nx;
    } plane_t;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]         kind;
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic [EXT_WIDTH-1:0]          extent_x;
        logic [EXT_WIDTH-1:0]          extent_y;
        logic [EXT_WIDTH-1:0]          extent_z;
    } query_t;

    typedef struct packed {
        logic                        hi_pos;
        logic                        lo_pos;
        logic signed [SUM_WIDTH-1:0] hi;
    } lane_res_t;

endpackage

// ----- hw/rtl/fcbv_plane_regs.sv -----
// fcbv_plane_regs: the six frustum plane registers and their write channel
// depends on fcbv_pkg
module fcbv_plane_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fcbv_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [fcbv_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    output fcbv_pkg::plane_t                    planes [fcbv_pkg::PLANE_COUNT]
);
    import fcbv_pkg::*;

    plane_t plane_reg [PLANE_COUNT];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PLANE_COUNT; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            // writes past the last plane are dropped
            for (int i = 0; i < PLANE_COUNT; i++) begin
                if (cfg_index == CFG_IDX_WIDTH'(i)) begin
                    plane_reg[i] <= plane_t'(cfg_data);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < PLANE_COUNT; i++) begin
            planes[i] = plane_reg[i];
        end
    end

endmodule

// ----- hw/rtl/fcbv_plane_lane.sv -----
// fcbv_plane_lane: one plane's test, a product register then sum and sign checks
// depends on fcbv_pkg
module fcbv_plane_lane (
    input  logic                aclk,
    input  logic                load,
    input  fcbv_pkg::plane_t    plane,
    input  fcbv_pkg::query_t    query,
    output fcbv_pkg::lane_res_t res
);
    import fcbv_pkg::*;

    logic signed [COEF_WIDTH-1:0]  coef     [AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] pos      [AXIS_COUNT];
    logic [EXT_WIDTH-1:0]          ext_sel  [AXIS_COUNT];

    logic signed [PROD_WIDTH-1:0]  pprod_reg [AXIS_COUNT];
    logic signed [PROD_WIDTH-1:0]  pprod_next[AXIS_COUNT];
    logic signed [EPROD_WIDTH-1:0] eprod_reg [AXIS_COUNT];
    logic signed [EPROD_WIDTH-1:0] eprod_next[AXIS_COUNT];
    logic signed [SUM_WIDTH-1:0]   off_reg, off_next;
    logic signed [SUM_WIDTH-1:0]   rad_reg, rad_next;
    logic [KIND_WIDTH-1:0]         kind_reg;

    always_comb begin
        coef[0] = plane.nx;
        coef[1] = plane.ny;
        coef[2] = plane.nz;
        pos[0]  = query.pos_x;
        pos[1]  = query.pos_y;
        pos[2]  = query.pos_z;
        // a cube spreads its half edge along every axis
        ext_sel[0] = query.extent_x;
        ext_sel[1] = (query.kind == KIND_CUBE) ? query.extent_x : query.extent_y;
        ext_sel[2] = (query.kind == KIND_CUBE) ? query.extent_x : query.extent_z;
        for (int a = 0; a < AXIS_COUNT; a++) begin
            pprod_next[a] = coef[a] * pos[a];
            eprod_next[a] = coef[a] * $signed({1'b0, ext_sel[a]});
        end
        off_next = SUM_WIDTH'(plane.off) <<< COEF_FRAC_BITS;
        rad_next = $signed(SUM_WIDTH'({query.extent_x, {COEF_FRAC_BITS{1'b0}}}));
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int a = 0; a < AXIS_COUNT; a++) begin
                pprod_reg[a] <= pprod_next[a];
                eprod_reg[a] <= eprod_next[a];
            end
            off_reg  <= off_next;
            rad_reg  <= rad_next;
            kind_reg <= query.kind;
        end
    end

    // the plane is linear: the best and worst corners follow from the signs
    // of the extent terms, so eight corners need not be visited
    always_comb begin
        logic signed [SUM_WIDTH-1:0] base;
        logic signed [SUM_WIDTH-1:0] term;
        logic signed [SUM_WIDTH-1:0] up_sum;
        logic signed [SUM_WIDTH-1:0] dn_sum;
        logic signed [SUM_WIDTH-1:0] lo;
        base   = off_reg;
        up_sum = (kind_reg == KIND_SPHERE) ? rad_reg : '0;
        dn_sum = '0;
        for (int a = 0; a < AXIS_COUNT; a++) begin
            base = base + SUM_WIDTH'(pprod_reg[a]);
            term = SUM_WIDTH'(eprod_reg[a]);
            case (kind_reg)
                KIND_CUBE: begin
                    up_sum = up_sum + ((term < 0) ? -term : term);
                end
                KIND_BOX: begin
                    if (term < 0) begin
                        dn_sum = dn_sum + term;
                    end else begin
                        up_sum = up_sum + term;
                    end
                end
                default: begin
                end
            endcase
        end
        res.hi     = base + up_sum;
        lo         = base + dn_sum;
        res.hi_pos = (res.hi > 0);
        res.lo_pos = (lo > 0);
    end

endmodule

// ----- hw/rtl/frustum_cull_bound_volume.sv -----
// frustum_cull_bound_volume: top level, input register, six plane lanes, result register
// depends on fcbv_pkg, fcbv_plane_regs and fcbv_plane_lane
//
// Culls one sphere, cube or box against six view frustum planes.
// The planes are written on the cfg channel (index 0 right .. 5 front,
// nx/ny/nz Q2.14 in the low three 16-bit fields, offset in the top one);
// write them only while no query is in flight. cfg_ready is always high.
// Queries arrive on s_t*: kind in s_tuser, position and extents in s_tdata.
// Each query yields exactly one result on m_t*: visibility and, for a
// visible sphere, the front plane distance plus radius in Q.14.
// The result passes the input register, the product registers and the result
// register in that order before it reaches m_tdata.
// Throughput: one query per cycle while m_tready stays high; every plane has
// its own three position and three extent multipliers, shared with no other plane.
// Stalls: each of the three stages holds its item while the next one is
// full, so s_tready drops only when all three stages are occupied and
// m_tready is low. Reset (aresetn low, synchronous) empties the pipeline
// and clears all six planes to zero.
module frustum_cull_bound_volume (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fcbv_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [fcbv_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    // queries
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pos_x, pos_y, pos_z, extent_x, extent_y, extent_z, zero pad
    input  logic [fcbv_pkg::S_DATA_WIDTH-1:0]   s_tdata,
    // kind
    input  logic [fcbv_pkg::KIND_WIDTH-1:0]     s_tuser,
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // visibility, near_distance
    output logic [fcbv_pkg::M_DATA_WIDTH-1:0]   m_tdata
);
    import fcbv_pkg::*;

    plane_t    planes [PLANE_COUNT];
    lane_res_t lane_res [PLANE_COUNT];

    query_t query_next, query_reg;
    logic   v1_reg, v2_reg, out_valid_reg;
    logic   rdy1, rdy2, rdy3;

    logic [VIS_WIDTH-1:0]  vis_next, vis_reg;
    logic [NEAR_WIDTH-1:0] near_next, near_reg;
    logic [KIND_WIDTH-1:0] kind2_reg;

    fcbv_plane_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    // per-stage ready: a stage takes a new item when empty or draining
    assign rdy3     = !out_valid_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_comb begin
        query_next.kind     = s_tuser;
        query_next.pos_x    = s_tdata[COORD_WIDTH-1:0];
        query_next.pos_y    = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
        query_next.pos_z    = s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
        query_next.extent_x = s_tdata[3*COORD_WIDTH+EXT_WIDTH-1:3*COORD_WIDTH];
        query_next.extent_y = s_tdata[3*COORD_WIDTH+2*EXT_WIDTH-1:3*COORD_WIDTH+EXT_WIDTH];
        query_next.extent_z = s_tdata[3*COORD_WIDTH+3*EXT_WIDTH-1:3*COORD_WIDTH+2*EXT_WIDTH];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && rdy1) begin
            query_reg <= query_next;
        end
        if (v1_reg && rdy2) begin
            kind2_reg <= query_reg.kind;
        end
        if (v2_reg && rdy3) begin
            vis_reg  <= vis_next;
            near_reg <= near_next;
        end
    end

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
        fcbv_plane_lane u_lane (
            .aclk  (aclk),
            .load  (v1_reg && rdy2),
            .plane (planes[p]),
            .query (query_reg),
            .res   (lane_res[p])
        );
    end

    always_comb begin
        logic all_hi;
        logic all_lo;
        all_hi = 1'b1;
        all_lo = 1'b1;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            all_hi = all_hi & lane_res[p].hi_pos;
            all_lo = all_lo & lane_res[p].lo_pos;
        end
        vis_next  = VIS_NONE;
        near_next = '0;
        case (kind2_reg)
            KIND_SPHERE: begin
                if (all_hi) begin
                    vis_next  = VIS_PART;
                    // positive and below 2^35, so zero extension into near_next loses nothing
                    near_next = {{(NEAR_WIDTH-SUM_WIDTH){1'b0}}, lane_res[PLANE_FRONT].hi};
                end
            end
            KIND_CUBE: begin
                vis_next = all_hi ? VIS_PART : VIS_NONE;
            end
            KIND_BOX: begin
                if (all_hi) begin
                    vis_next = all_lo ? VIS_WHOLE : VIS_PART;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {near_reg, vis_reg};

`ifndef ASSERT_OFF
    a_vis_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (vis_reg == VIS_NONE || vis_reg == VIS_PART || vis_reg == VIS_WHOLE))
        else $error("result carries an undefined visibility code");

    a_near_only_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && near_reg != '0) |-> (vis_reg == VIS_PART))
        else $error("near distance set on a result that is not a visible sphere");

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && out_valid_reg && !m_tready))
        else $error("input stalled while the pipeline has room");

    a_stage2_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !rdy3) |=> v2_reg)
        else $error("product stage dropped an item while the result stage stalled");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(vis_reg) && $stable(near_reg)))
        else $error("stalled result changed");
`endif

endmodule

// ----- dv/tb_frustum_cull_bound_volume.sv -----
// tb_frustum_cull_bound_volume: self-checking bench for the six-plane frustum culling block
// drives plane writes and sphere/cube/box queries, predicts visibility and near distance
// depends on fcbv_pkg and frustum_cull_bound_volume
module tb_frustum_cull_bound_volume;
    import fcbv_pkg::*;

    localparam logic [KIND_WIDTH-1:0] KIND_RESERVED = 2'd3;
    localparam int    ONE_Q    = 1 << COEF_FRAC_BITS;
    localparam longint NEAR_MAX = (longint'(1) <<< NEAR_WIDTH) - 1;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_RIGHT, REG_LEFT, REG_BOTTOM, REG_TOP, REG_BACK, REG_FRONT,
        REG_SPARE_6, REG_SPARE_7
    } plane_reg_t;

    typedef struct {
        logic [VIS_WIDTH-1:0]  vis;
        logic [NEAR_WIDTH-1:0] near;
    } cull_res_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;
    logic                      s_tvalid;
    logic                      s_tready;
    // pos_x, pos_y, pos_z, extent_x, extent_y, extent_z, zero pad
    logic [S_DATA_WIDTH-1:0]   s_tdata;
    // kind
    logic [KIND_WIDTH-1:0]     s_tuser;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    // visibility, near_distance
    logic [M_DATA_WIDTH-1:0]   m_tdata;

    plane_t    plane_shadow [PLANE_COUNT];
    cull_res_t expected_cull [$];
    bit        feed_gaps_on;
    bit        drain_stalls_on;
    int        stall_left;
    int        error_count;
    int        kinds_sent [4];
    int        results_checked;
    int        vis_seen [4];
    int        plane_writes;

    frustum_cull_bound_volume DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #6000000;
        $display("tb_frustum_cull_bound_volume: done, errors");
        $finish;
    end

    // plane value at a point, scaled by 2^COEF_FRAC_BITS
    function automatic longint plane_eval(plane_t pl, longint x, longint y, longint z);
        return longint'($signed(pl.nx)) * x + longint'($signed(pl.ny)) * y
             + longint'($signed(pl.nz)) * z
             + longint'($signed(pl.off)) * (longint'(1) <<< COEF_FRAC_BITS);
    endfunction

    function automatic int lit_corners(plane_t pl, longint lx, longint ly, longint lz,
                                       longint hx, longint hy, longint hz);
        int n;
        n = 0;
        for (int c = 0; c < 8; c++) begin
            if (plane_eval(pl, c[0] ? hx : lx, c[1] ? hy : ly, c[2] ? hz : lz) > 0)
                n++;
        end
        return n;
    endfunction

    function automatic cull_res_t predict_cull(query_t q);
        cull_res_t r;
        longint    px, py, pz, ex, ey, ez, rs, d, s;
        int        n, whole;
        bit        seen;
        r.vis  = VIS_NONE;
        r.near = '0;
        px = longint'($signed(q.pos_x));
        py = longint'($signed(q.pos_y));
        pz = longint'($signed(q.pos_z));
        ex = longint'(q.extent_x);
        ey = longint'(q.extent_y);
        ez = longint'(q.extent_z);
        case (q.kind)
            KIND_SPHERE: begin
                rs   = ex * (longint'(1) <<< COEF_FRAC_BITS);
                d    = 0;
                seen = 1'b1;
                for (int p = 0; p < PLANE_COUNT; p++) begin
                    d = plane_eval(plane_shadow[p], px, py, pz);
                    if (d <= -rs) begin
                        seen = 1'b0;
                        break;
                    end
                end
                // d now holds the front plane value
                if (seen) begin
                    s      = d + rs;
                    r.vis  = VIS_PART;
                    r.near = NEAR_WIDTH'((s > NEAR_MAX) ? NEAR_MAX : s);
                end
            end
            KIND_CUBE: begin
                r.vis = VIS_PART;
                for (int p = 0; p < PLANE_COUNT; p++) begin
                    if (lit_corners(plane_shadow[p], px - ex, py - ex, pz - ex,
                                    px + ex, py + ex, pz + ex) == 0) begin
                        r.vis = VIS_NONE;
                        break;
                    end
                end
            end
            KIND_BOX: begin
                r.vis = VIS_PART;
                whole = 0;
                for (int p = 0; p < PLANE_COUNT; p++) begin
                    n = lit_corners(plane_shadow[p], px, py, pz, px + ex, py + ey, pz + ez);
                    if (n == 0) begin
                        r.vis = VIS_NONE;
                        break;
                    end
                    if (n == 8)
                        whole++;
                end
                if (r.vis == VIS_PART && whole == PLANE_COUNT)
                    r.vis = VIS_WHOLE;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic plane_t make_plane(int nx, int ny, int nz, int off);
        plane_t pl;
        pl.nx  = COEF_WIDTH'(nx);
        pl.ny  = COEF_WIDTH'(ny);
        pl.nz  = COEF_WIDTH'(nz);
        pl.off = COEF_WIDTH'(off);
        return pl;
    endfunction

    function automatic query_t make_query(logic [KIND_WIDTH-1:0] kind, int px, int py, int pz,
                                          int ex, int ey, int ez);
        query_t q;
        q.kind     = kind;
        q.pos_x    = COORD_WIDTH'(px);
        q.pos_y    = COORD_WIDTH'(py);
        q.pos_z    = COORD_WIDTH'(pz);
        q.extent_x = EXT_WIDTH'(ex);
        q.extent_y = EXT_WIDTH'(ey);
        q.extent_z = EXT_WIDTH'(ez);
        return q;
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic query_t random_query(bit full_range, int span);
        query_t q;
        int     k;
        k = $urandom_range(0, 19);
        q.kind = (k < 6) ? KIND_SPHERE : (k < 12) ? KIND_CUBE : (k < 19) ? KIND_BOX
                                                                           : KIND_RESERVED;
        if (full_range || $urandom_range(0, 15) == 0) begin
            q.pos_x = COORD_WIDTH'($urandom);
            q.pos_y = COORD_WIDTH'($urandom);
            q.pos_z = COORD_WIDTH'($urandom);
        end else begin
            q.pos_x = COORD_WIDTH'(jitter(span));
            q.pos_y = COORD_WIDTH'(jitter(span));
            q.pos_z = COORD_WIDTH'(jitter(span));
        end
        if (full_range || $urandom_range(0, 7) == 0) begin
            q.extent_x = EXT_WIDTH'($urandom);
            q.extent_y = EXT_WIDTH'($urandom);
            q.extent_z = EXT_WIDTH'($urandom);
        end else begin
            q.extent_x = EXT_WIDTH'($urandom_range(0, span / 3));
            q.extent_y = EXT_WIDTH'($urandom_range(0, span / 3));
            q.extent_z = EXT_WIDTH'($urandom_range(0, span / 3));
        end
        return q;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 30)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // one query transfer; the expectation is taken with the planes in force at acceptance
    task automatic send_query(input query_t q);
        if (feed_gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, q.extent_z, q.extent_y, q.extent_x, q.pos_z, q.pos_y, q.pos_x};
        s_tuser  <= q.kind;
        do @(posedge aclk); while (!s_tready);
        expected_cull.push_back(predict_cull(q));
        kinds_sent[q.kind]++;
    endtask

    task automatic write_plane(input plane_reg_t idx, input logic [CFG_DATA_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (int'(idx) < PLANE_COUNT)
            plane_shadow[int'(idx)] = value;
        plane_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // planes may only change with no query in flight
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_cull.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // box of half width half_w around the origin, normals pointing inward
    task automatic load_frustum(input int half_w, input int tilt);
        wait_drain();
        write_plane(REG_RIGHT,  make_plane(-ONE_Q, jitter(tilt), jitter(tilt), half_w));
        write_plane(REG_LEFT,   make_plane(ONE_Q, jitter(tilt), jitter(tilt), half_w));
        write_plane(REG_BOTTOM, make_plane(jitter(tilt), ONE_Q, jitter(tilt), half_w));
        write_plane(REG_TOP,    make_plane(jitter(tilt), -ONE_Q, jitter(tilt), half_w));
        write_plane(REG_BACK,   make_plane(jitter(tilt), jitter(tilt), -ONE_Q, half_w));
        write_plane(REG_FRONT,  make_plane(jitter(tilt), jitter(tilt), ONE_Q, half_w));
    endtask

    task automatic load_uniform(input logic [CFG_DATA_WIDTH-1:0] value);
        wait_drain();
        for (int p = 0; p < PLANE_COUNT; p++)
            write_plane(plane_reg_t'(p), value);
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (drain_stalls_on && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cull_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_cull.size() == 0) begin
                report_mismatch($sformatf("result %h with no query pending", m_tdata));
            end else begin
                want = expected_cull.pop_front();
                results_checked++;
                vis_seen[want.vis]++;
                if (m_tdata[VIS_WIDTH-1:0] !== want.vis)
                    report_mismatch($sformatf("visibility %0d, expected %0d",
                                              m_tdata[VIS_WIDTH-1:0], want.vis));
                if (m_tdata[VIS_WIDTH +: NEAR_WIDTH] !== want.near)
                    report_mismatch($sformatf("near_distance %0d, expected %0d",
                                              m_tdata[VIS_WIDTH +: NEAR_WIDTH], want.near));
            end
        end
    end

    // all planes zero: every plane value is zero, so only spheres with a radius survive
    task automatic test_reset_planes();
        send_query(make_query(KIND_SPHERE, 0, 0, 0, 0, 0, 0));
        send_query(make_query(KIND_SPHERE, 100, -5, 7, 1, 0, 0));
        send_query(make_query(KIND_CUBE, 0, 0, 0, 32767, 0, 0));
        send_query(make_query(KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767));
        send_query(make_query(KIND_RESERVED, 1, 2, 3, 4, 5, 6));
    endtask

    task automatic test_axis_frustum();
        load_frustum(1000, 0);
        // sphere exactly touching the right plane from outside is culled
        send_query(make_query(KIND_SPHERE, 1100, 0, 0, 100, 0, 0));
        send_query(make_query(KIND_SPHERE, 1099, 0, 0, 100, 0, 0));
        // unused extents carry full-scale junk
        send_query(make_query(KIND_SPHERE, 0, 0, -500, 30, 32767, 32767));
        send_query(make_query(KIND_CUBE, 1005, 0, 0, 5, 32767, 32767));
        send_query(make_query(KIND_CUBE, 1004, 0, 0, 5, 0, 0));
        send_query(make_query(KIND_BOX, -10, -10, -10, 20, 20, 20));
        send_query(make_query(KIND_BOX, 990, 0, 0, 20, 1, 1));
        send_query(make_query(KIND_BOX, 1000, 0, 0, 5, 5, 5));
        send_query(make_query(KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767));
        send_query(make_query(KIND_RESERVED, 0, 0, 0, 0, 0, 0));
    endtask

    // writes to indexes past the last plane must leave the planes alone
    task automatic test_unused_index();
        wait_drain();
        write_plane(REG_SPARE_6, {CFG_DATA_WIDTH{1'b1}});
        write_plane(REG_SPARE_7, 64'h8000_0000_0000_0000);
        send_query(make_query(KIND_SPHERE, 0, 0, 0, 10, 0, 0));
        send_query(make_query(KIND_BOX, -10, -10, -10, 20, 20, 20));
    endtask

    task automatic test_extreme_planes();
        load_uniform(64'h8000_8000_8000_8000);
        send_query(make_query(KIND_SPHERE, -32768, -32768, -32768, 32767, 0, 0));
        send_query(make_query(KIND_CUBE, 32767, 32767, 32767, 32767, 0, 0));
        send_query(make_query(KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767));
        load_uniform(64'h7FFF_7FFF_7FFF_7FFF);
        send_query(make_query(KIND_SPHERE, 32767, 32767, 32767, 32767, 0, 0));
        send_query(make_query(KIND_CUBE, -32768, -32768, -32768, 32767, 0, 0));
        send_query(make_query(KIND_BOX, 32767, 32767, 32767, 32767, 32767, 32767));
    endtask

    task automatic test_random_frustums();
        int half_w;
        for (int ph = 0; ph < 6; ph++) begin
            half_w = (ph == 5) ? 16000 : $urandom_range(50, 12000);
            load_frustum(half_w, (ph % 2) ? 3000 : 0);
            feed_gaps_on    = (ph != 2);
            drain_stalls_on = (ph != 3);
            for (int i = 0; i < 150; i++)
                send_query(random_query(1'b0, half_w + half_w / 4));
        end
    endtask

    task automatic test_random_planes();
        for (int ph = 0; ph < 3; ph++) begin
            wait_drain();
            for (int p = 0; p < PLANE_COUNT; p++)
                write_plane(plane_reg_t'(p), {$urandom, $urandom});
            feed_gaps_on    = 1'b1;
            drain_stalls_on = 1'b1;
            for (int i = 0; i < 100; i++)
                send_query(random_query(1'b1, 0));
        end
    endtask

    // closing stretch at full rate in both directions
    task automatic test_streaming();
        load_frustum(4000, 1500);
        feed_gaps_on    = 1'b0;
        drain_stalls_on = 1'b0;
        for (int i = 0; i < 250; i++)
            send_query(random_query($urandom_range(0, 4) == 0, 5000));
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        for (int p = 0; p < PLANE_COUNT; p++)
            plane_shadow[p] = '0;
        feed_gaps_on    = 1'b1;
        drain_stalls_on = 1'b1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_planes();
        test_axis_frustum();
        test_unused_index();
        test_extreme_planes();
        test_random_frustums();
        test_random_planes();
        test_streaming();

        wait_drain();
        repeat (8) @(posedge aclk);
        $display("queries: %0d sphere, %0d cube, %0d box, %0d reserved kind; %0d plane writes",
                 kinds_sent[0], kinds_sent[1], kinds_sent[2], kinds_sent[3], plane_writes);
        $display("results checked: %0d (%0d culled, %0d visible or partial, %0d whole box)",
                 results_checked, vis_seen[0], vis_seen[1], vis_seen[2]);
        if (error_count == 0 && expected_cull.size() == 0) begin
            $display("tb_frustum_cull_bound_volume: done, clean");
        end else begin
            $display("tb_frustum_cull_bound_volume: done, errors");
        end
        $finish;
    end

endmodule
